>>> hdl/plrm_pkg.sv
// Shared types and constants for the ping latency and rate monitor.
// Depends on nothing; every other file of the block imports it.
package plrm_pkg;

   // Ping queue depth default, handed down from the top level
   localparam int QUEUE_DEPTH_DEF = 16;

   // Field widths
   localparam int ID_W         = 32;
   localparam int TIME_W       = 32;
   localparam int BYTES_W      = 32;
   localparam int TOTAL_W      = 48;
   localparam int INTERVAL_W   = 16;
   localparam int KIND_W       = 3;
   // byte total times 1000 needs ten more bits
   localparam int DIVIDEND_W   = TOTAL_W + 10;

   // Reset values
   localparam logic [INTERVAL_W-1:0] RATE_INTERVAL_RST = 16'd1000;
   localparam logic [ID_W-1:0]       FIRST_PING_ID     = 32'd1;

   // Command queue between front and back
   localparam int CMD_FIFO_DEPTH = 2;
   localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
   localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

   // Decoded operation of one item
   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_REPLY = 2'd1,
      OP_BYTES = 2'd2,
      OP_RATE  = 2'd3
   } op_type;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_SENT     = 3'd0,
      KIND_LATENCY  = 3'd1,
      KIND_NO_MATCH = 3'd2,
      KIND_RATE     = 3'd3,
      KIND_BYTES    = 3'd4
   } kind_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_DIV_START,
      ST_DIV_WAIT
   } back_state_type;

   // One classified command
   typedef struct packed {
      op_type               op;
      logic [TIME_W-1:0]    now_ms;
      logic [ID_W-1:0]      reply_id;
      logic [BYTES_W-1:0]   byte_count;
   } cmd_type;

endpackage

>>> hdl/ping_latency_and_rate_monitor_top.sv
// Ping round-trip and link data-rate monitor.
// Items arrive on req_* (valid/ready) with a mode: send ping, ping reply,
// bytes received or rate period end. Every item gives exactly one result on
// rsp_* (valid/ready); kind tells which fields carry data, the rest are zero.
// csr_we/csr_wdata write the rate interval in ms (0 acts as 1).
// A two-entry command queue parts the front from the back, so items are
// accepted while a result waits. A reply walks the ping queue from the head,
// popping each entry examined until an id matches or the queue is empty; a
// rate end runs the one bit per cycle divider over the 58-bit scaled byte
// total. The back end works on one item at a time and takes no new command
// until the current one has its result.
// A stalled receiver holds the result; the command queue fills and req_ready
// drops once it is full. Reset (synchronous) empties the ping queue, sets the
// next ping id to 1, clears the byte total and sets the interval to 1000 ms.
// Depends on plrm_pkg, plrm_front, plrm_back and plrm_div.
module ping_latency_and_rate_monitor_top #(
   parameter int QUEUE_DEPTH = plrm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [plrm_pkg::INTERVAL_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [plrm_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [plrm_pkg::ID_W-1:0]         req_reply_id,
   input  logic [plrm_pkg::BYTES_W-1:0]      req_byte_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [plrm_pkg::KIND_W-1:0]       rsp_kind,
   output logic [plrm_pkg::ID_W-1:0]         rsp_sent_id,
   output logic [plrm_pkg::TIME_W-1:0]       rsp_latency_ms,
   output logic [plrm_pkg::TOTAL_W-1:0]      rsp_byte_rate,
   output logic                              rsp_oldest_dropped
);
   import plrm_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_data;

   // Accept and classify items
   plrm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_now_ms     (req_now_ms),
      .req_reply_id   (req_reply_id),
      .req_byte_count (req_byte_count),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd_data       (cmd_data)
   );

   // Carry out commands and hold results
   plrm_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .cmd_valid          (cmd_valid),
      .cmd_ready          (cmd_ready),
      .cmd_data           (cmd_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_sent_id        (rsp_sent_id),
      .rsp_latency_ms     (rsp_latency_ms),
      .rsp_byte_rate      (rsp_byte_rate),
      .rsp_oldest_dropped (rsp_oldest_dropped)
   );

endmodule

>>> hdl/plrm_front.sv
// Front end: accepts items, decodes the mode and queues commands for the back end.
// Depends on plrm_pkg.
module plrm_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_mode,
   input  logic [plrm_pkg::TIME_W-1:0]  req_now_ms,
   input  logic [plrm_pkg::ID_W-1:0]    req_reply_id,
   input  logic [plrm_pkg::BYTES_W-1:0] req_byte_count,
   output logic                       cmd_valid,
   input  logic                       cmd_ready,
   output plrm_pkg::cmd_type          cmd_data
);
   import plrm_pkg::*;

   cmd_type              fifo_ff [CMD_FIFO_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   cmd_type              new_cmd;
   logic                 push;
   logic                 pop;

   // Classify the incoming item
   always_comb begin
      new_cmd.op         = op_type'(req_mode);
      new_cmd.now_ms     = req_now_ms;
      new_cmd.reply_id   = req_reply_id;
      new_cmd.byte_count = req_byte_count;
   end

   assign req_ready = (count_ff != CMD_CNT_W'(CMD_FIFO_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = fifo_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the command payload
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> hdl/plrm_div.sv
// Restoring divider, one quotient bit per cycle, for the rate computation.
// Depends on plrm_pkg.
module plrm_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [plrm_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [plrm_pkg::INTERVAL_W-1:0]  divisor,
   output logic                             done,
   output logic [plrm_pkg::DIVIDEND_W-1:0]  quotient
);
   import plrm_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [INTERVAL_W-1:0] rem_ff, rem_in;
   logic [INTERVAL_W-1:0] den_ff, den_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [INTERVAL_W:0]   shifted;
   logic [INTERVAL_W:0]   diff;
   logic                  fits;

   // Trial subtract of one bit
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[INTERVAL_W-1:0] : shifted[INTERVAL_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/plrm_back.sv
// Back end: ping queue memory, reply walk, byte total, rate division and result register.
// Depends on plrm_pkg and plrm_div.
module plrm_back #(
   parameter int QUEUE_DEPTH = plrm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [plrm_pkg::INTERVAL_W-1:0]   csr_wdata,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  plrm_pkg::cmd_type                 cmd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [plrm_pkg::KIND_W-1:0]       rsp_kind,
   output logic [plrm_pkg::ID_W-1:0]         rsp_sent_id,
   output logic [plrm_pkg::TIME_W-1:0]       rsp_latency_ms,
   output logic [plrm_pkg::TOTAL_W-1:0]      rsp_byte_rate,
   output logic                              rsp_oldest_dropped
);
   import plrm_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ENT_W = ID_W + TIME_W;

   // Ping queue storage
   logic [ENT_W-1:0]      queue_mem [QUEUE_DEPTH];
   logic [ENT_W-1:0]      entry_ff;
   logic                  mem_we;
   logic [PTR_W-1:0]      mem_waddr;

   back_state_type        state_ff, state_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [ID_W-1:0]       reply_id_ff, reply_id_in;
   logic [DIVIDEND_W-1:0] prod_ff, prod_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]       rsp_sent_id_ff, rsp_sent_id_in;
   logic [TIME_W-1:0]     rsp_latency_ms_ff, rsp_latency_ms_in;
   logic [TOTAL_W-1:0]    rsp_byte_rate_ff, rsp_byte_rate_in;
   logic                  rsp_dropped_ff, rsp_dropped_in;

   logic                  out_free;
   logic                  queue_full;
   logic                  queue_empty;
   logic [PTR_W-1:0]      head_inc;
   logic [CNT_W:0]        slot_sum;
   logic [PTR_W-1:0]      slot;
   logic                  id_match;
   logic [TOTAL_W:0]      byte_sum;
   logic [DIVIDEND_W-1:0] total_ext;
   logic [DIVIDEND_W-1:0] scaled_total;
   logic [INTERVAL_W-1:0] divisor;
   logic                  div_start;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;
   logic [TOTAL_W-1:0]    rate_sat;

   // Queue bookkeeping
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign head_inc    = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign slot_sum    = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
   // A full queue reuses the head slot of the dropped entry
   always_comb begin
      if (queue_full) begin
         slot = head_ff;
      end else if (slot_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         slot = PTR_W'(slot_sum - (CNT_W + 1)'(QUEUE_DEPTH));
      end else begin
         slot = slot_sum[PTR_W-1:0];
      end
   end
   assign id_match = (entry_ff[ENT_W-1:TIME_W] == reply_id_ff);

   // Saturating byte accumulate
   assign byte_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(cmd_data.byte_count);

   // Total times 1000 as 1024 - 16 - 8
   assign total_ext    = DIVIDEND_W'(total_ff);
   assign scaled_total = (total_ext << 10) - (total_ext << 4) - (total_ext << 3);

   assign divisor  = (interval_ff == '0) ? INTERVAL_W'(1) : interval_ff;
   assign rate_sat = (div_quotient[DIVIDEND_W-1:TOTAL_W] != '0) ? '1
                                                                : div_quotient[TOTAL_W-1:0];

   plrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               case (cmd_data.op)
                  OP_REPLY: state_in = ST_WALK_RD;
                  OP_RATE:  state_in = ST_DIV_START;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_WALK_RD: begin
            state_in = queue_empty ? ST_IDLE : ST_WALK_CMP;
         end
         ST_WALK_CMP: begin
            state_in = id_match ? ST_IDLE : ST_WALK_RD;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result control
   always_comb begin
      cmd_ready         = 1'b0;
      mem_we            = 1'b0;
      mem_waddr         = slot;
      div_start         = 1'b0;
      head_in           = head_ff;
      count_in          = count_ff;
      next_id_in        = next_id_ff;
      total_in          = total_ff;
      now_in            = now_ff;
      reply_id_in       = reply_id_ff;
      prod_in           = prod_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_kind_in       = rsp_kind_ff;
      rsp_sent_id_in    = rsp_sent_id_ff;
      rsp_latency_ms_in = rsp_latency_ms_ff;
      rsp_byte_rate_in  = rsp_byte_rate_ff;
      rsp_dropped_in    = rsp_dropped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               case (cmd_data.op)
                  OP_SEND: begin
                     // Queue the ping, drop the oldest when full
                     mem_we            = 1'b1;
                     next_id_in        = next_id_ff + 1'b1;
                     if (queue_full) begin
                        head_in = head_inc;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                     rsp_valid_in      = 1'b1;
                     rsp_kind_in       = KIND_SENT;
                     rsp_sent_id_in    = next_id_ff;
                     rsp_latency_ms_in = '0;
                     rsp_byte_rate_in  = '0;
                     rsp_dropped_in    = queue_full;
                  end
                  OP_REPLY: begin
                     now_in      = cmd_data.now_ms;
                     reply_id_in = cmd_data.reply_id;
                  end
                  OP_BYTES: begin
                     total_in          = byte_sum[TOTAL_W] ? '1 : byte_sum[TOTAL_W-1:0];
                     rsp_valid_in      = 1'b1;
                     rsp_kind_in       = KIND_BYTES;
                     rsp_sent_id_in    = '0;
                     rsp_latency_ms_in = '0;
                     rsp_byte_rate_in  = '0;
                     rsp_dropped_in    = 1'b0;
                  end
                  default: begin
                     // Rate period end: latch scaled total, clear it
                     prod_in  = scaled_total;
                     total_in = '0;
                  end
               endcase
            end
         end
         ST_WALK_RD: begin
            if (queue_empty) begin
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = KIND_NO_MATCH;
               rsp_sent_id_in    = '0;
               rsp_latency_ms_in = '0;
               rsp_byte_rate_in  = '0;
               rsp_dropped_in    = 1'b0;
            end
         end
         ST_WALK_CMP: begin
            // Pop the head whether or not it matches
            head_in  = head_inc;
            count_in = count_ff - 1'b1;
            if (id_match) begin
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = KIND_LATENCY;
               rsp_sent_id_in    = '0;
               rsp_latency_ms_in = now_ff - entry_ff[TIME_W-1:0];
               rsp_byte_rate_in  = '0;
               rsp_dropped_in    = 1'b0;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = KIND_RATE;
               rsp_sent_id_in    = '0;
               rsp_latency_ms_in = '0;
               rsp_byte_rate_in  = rate_sat;
               rsp_dropped_in    = 1'b0;
            end
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         next_id_ff   <= FIRST_PING_ID;
         total_ff     <= '0;
         interval_ff  <= RATE_INTERVAL_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            interval_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff            <= now_in;
      reply_id_ff       <= reply_id_in;
      prod_ff           <= prod_in;
      rsp_kind_ff       <= rsp_kind_in;
      rsp_sent_id_ff    <= rsp_sent_id_in;
      rsp_latency_ms_ff <= rsp_latency_ms_in;
      rsp_byte_rate_ff  <= rsp_byte_rate_in;
      rsp_dropped_ff    <= rsp_dropped_in;
   end

   // Write the ping queue, read the head entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[mem_waddr] <= {next_id_ff, cmd_data.now_ms};
      end
      entry_ff <= queue_mem[head_ff];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_sent_id        = rsp_sent_id_ff;
   assign rsp_latency_ms     = rsp_latency_ms_ff;
   assign rsp_byte_rate      = rsp_byte_rate_ff;
   assign rsp_oldest_dropped = rsp_dropped_ff;

endmodule

>>> bench/plrm_checker.sv
// Scoreboard for the ping latency and rate monitor: watches both channels and the csr port,
// predicts each result from its own copy of the ping queue and byte total, compares in order.
// Depends on plrm_pkg for widths, op codes and result kinds.
module plrm_checker #(
   parameter int QUEUE_DEPTH = plrm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [plrm_pkg::INTERVAL_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [plrm_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [plrm_pkg::ID_W-1:0]         req_reply_id,
   input  logic [plrm_pkg::BYTES_W-1:0]      req_byte_count,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [plrm_pkg::KIND_W-1:0]       rsp_kind,
   input  logic [plrm_pkg::ID_W-1:0]         rsp_sent_id,
   input  logic [plrm_pkg::TIME_W-1:0]       rsp_latency_ms,
   input  logic [plrm_pkg::TOTAL_W-1:0]      rsp_byte_rate,
   input  logic                              rsp_oldest_dropped,
   output int                                fail_count,
   output int                                results_owed
);
   import plrm_pkg::*;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef struct packed {
      kind_type              kind;
      logic [ID_W-1:0]       sent_id;
      logic [TIME_W-1:0]     latency_ms;
      logic [TOTAL_W-1:0]    byte_rate;
      logic                  oldest_dropped;
   } ping_result_type;

   // Shadow of the block state
   logic [ID_W-1:0]       ping_ids   [QUEUE_DEPTH];
   logic [TIME_W-1:0]     ping_times [QUEUE_DEPTH];
   int                    ping_head;
   int                    ping_count;
   logic [ID_W-1:0]       next_id;
   logic [TOTAL_W-1:0]    byte_total;
   logic [INTERVAL_W-1:0] interval_ms;

   ping_result_type owed_results[$];

   // Print one mismatch line and count it
   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h, expected %0h", field, got, want);
      fail_count++;
   endtask

   // Drop the oldest queued ping
   task automatic pop_ping();
      if (ping_count > 0) begin
         ping_head  = (ping_head + 1) % QUEUE_DEPTH;
         ping_count = ping_count - 1;
      end
   endtask

   // Apply one item to the shadow state and work out its result
   task automatic advance_monitor(input op_type op, input logic [TIME_W-1:0] now,
                                  input logic [ID_W-1:0] rid,
                                  input logic [BYTES_W-1:0] bytes,
                                  output ping_result_type res);
      int                  slot;
      logic [TOTAL_W:0]    sum;
      logic [63:0]         scaled;
      logic [63:0]         quot;
      logic [63:0]         divisor;
      res = '0;
      case (op)
         OP_SEND: begin
            if (ping_count >= QUEUE_DEPTH) begin
               pop_ping();
               res.oldest_dropped = 1'b1;
            end
            slot             = (ping_head + ping_count) % QUEUE_DEPTH;
            ping_ids[slot]   = next_id;
            ping_times[slot] = now;
            ping_count       = ping_count + 1;
            res.kind         = KIND_SENT;
            res.sent_id      = next_id;
            next_id          = next_id + 1'b1;
         end
         OP_REPLY: begin
            // walk past older pings until the head id matches
            while (ping_count > 0 && ping_ids[ping_head] != rid)
               pop_ping();
            if (ping_count > 0) begin
               res.kind       = KIND_LATENCY;
               res.latency_ms = now - ping_times[ping_head];
               pop_ping();
            end else begin
               res.kind = KIND_NO_MATCH;
            end
         end
         OP_BYTES: begin
            sum        = {1'b0, byte_total} + {{(TOTAL_W + 1 - BYTES_W){1'b0}}, bytes};
            byte_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            res.kind   = KIND_BYTES;
         end
         default: begin
            // zero interval acts as one
            divisor = (interval_ms == '0) ? 64'd1 : {48'd0, interval_ms};
            scaled  = {16'd0, byte_total} * 64'd1000;
            quot    = scaled / divisor;
            res.byte_rate = (quot > {16'd0, TOTAL_MAX}) ? TOTAL_MAX : quot[TOTAL_W-1:0];
            res.kind      = KIND_RATE;
            byte_total    = '0;
         end
      endcase
   endtask

   // Track config, compare results, predict accepted items
   always @(posedge clock) begin
      ping_result_type want;
      ping_result_type fresh;
      if (reset) begin
         ping_head   = 0;
         ping_count  = 0;
         next_id     = FIRST_PING_ID;
         byte_total  = '0;
         interval_ms = RATE_INTERVAL_RST;
         fail_count  = 0;
         owed_results.delete();
      end else begin
         if (csr_we)
            interval_ms = csr_wdata;
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result with nothing owed, kind", rsp_kind, 0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", rsp_kind, want.kind);
               if (rsp_sent_id !== want.sent_id)
                  report_mismatch("sent_id", rsp_sent_id, want.sent_id);
               if (rsp_latency_ms !== want.latency_ms)
                  report_mismatch("latency_ms", rsp_latency_ms, want.latency_ms);
               if (rsp_byte_rate !== want.byte_rate)
                  report_mismatch("byte_rate", rsp_byte_rate, want.byte_rate);
               if (rsp_oldest_dropped !== want.oldest_dropped)
                  report_mismatch("oldest_dropped", rsp_oldest_dropped, want.oldest_dropped);
            end
         end
         if (req_valid && req_ready) begin
            advance_monitor(op_type'(req_mode), req_now_ms, req_reply_id, req_byte_count,
                            fresh);
            owed_results.push_back(fresh);
         end
      end
      results_owed = owed_results.size();
   end

endmodule

>>> bench/tb.sv
// Top of the ping latency and rate monitor bench: clock, reset, stimulus and verdict.
// Depends on plrm_pkg, the block ping_latency_and_rate_monitor_top and plrm_checker.
module tb;
   import plrm_pkg::*;

   localparam int QUEUE_DEPTH      = QUEUE_DEPTH_DEF;
   localparam int CYCLE_LIMIT      = 500_000;
   localparam int SETTLE_CYCLES    = 2 * QUEUE_DEPTH + 70;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS      = 85;
   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [INTERVAL_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_mode;
   logic [TIME_W-1:0]     req_now_ms;
   logic [ID_W-1:0]       req_reply_id;
   logic [BYTES_W-1:0]    req_byte_count;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [KIND_W-1:0]     rsp_kind;
   logic [ID_W-1:0]       rsp_sent_id;
   logic [TIME_W-1:0]     rsp_latency_ms;
   logic [TOTAL_W-1:0]    rsp_byte_rate;
   logic                  rsp_oldest_dropped;

   int fail_count;
   int results_owed;
   int cycle_count;
   int items_sent;
   int hold_left;

   logic [ID_W-1:0]   pings_sent;
   logic [TIME_W-1:0] wall_ms;
   bit                offering;
   bit                calm;
   bit                long_hold_req;

   ping_latency_and_rate_monitor_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_now_ms         (req_now_ms),
      .req_reply_id       (req_reply_id),
      .req_byte_count     (req_byte_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_sent_id        (rsp_sent_id),
      .rsp_latency_ms     (rsp_latency_ms),
      .rsp_byte_rate      (rsp_byte_rate),
      .rsp_oldest_dropped (rsp_oldest_dropped)
   );

   plrm_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_now_ms         (req_now_ms),
      .req_reply_id       (req_reply_id),
      .req_byte_count     (req_byte_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_sent_id        (rsp_sent_id),
      .rsp_latency_ms     (rsp_latency_ms),
      .rsp_byte_rate      (rsp_byte_rate),
      .rsp_oldest_dropped (rsp_oldest_dropped),
      .fail_count         (fail_count),
      .results_owed       (results_owed)
   );

   // Free-running clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Gap length: mostly short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 15);
      else
         return $urandom_range(30, 80);
   endfunction

   // Drive rsp_ready: long hold on request, random gaps otherwise
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
         end else if (!calm && $urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            hold_left = gap_len() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one item and hold it until accepted
   task automatic issue(op_type op, logic [TIME_W-1:0] now, logic [ID_W-1:0] rid,
                        logic [BYTES_W-1:0] bytes);
      req_mode       <= op;
      req_now_ms     <= now;
      req_reply_id   <= rid;
      req_byte_count <= bytes;
      req_valid      <= 1'b1;
      offering = 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
      items_sent++;
      if (op == OP_SEND)
         pings_sent = pings_sent + 1'b1;
   endtask

   // Drop valid once
   task automatic lower_valid();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // Idle the sender for a random stretch
   task automatic sender_pause();
      int n;
      n = (calm || $urandom_range(0, 99) >= 35) ? 0 : gap_len();
      if (n > 0) begin
         lower_valid();
         repeat (n) @(negedge clock);
      end
   endtask

   // Hold off until every owed result has come back
   task automatic drain();
      lower_valid();
      while (results_owed != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the rate interval while the block is idle
   task automatic write_interval(logic [INTERVAL_W-1:0] value);
      drain();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Advance the wall clock: small steps, some big jumps
   task automatic advance_wall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         wall_ms = wall_ms + $urandom_range(0, 200);
      else if (r < 95)
         wall_ms = wall_ms + $urandom_range(1000, 100000);
      else
         wall_ms = $urandom;
   endtask

   // Send a burst of pings, then answer most of them in order
   task automatic ping_round();
      int              k;
      logic [ID_W-1:0] first;
      first = pings_sent + 1'b1;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
      for (int i = 0; i < k; i++) begin
         advance_wall();
         issue(OP_SEND, wall_ms, $urandom, $urandom);
         sender_pause();
      end
      for (int i = 0; i < k; i++) begin
         if ($urandom_range(0, 99) < 70) begin
            advance_wall();
            issue(OP_REPLY, wall_ms, first + i, $urandom);
            sender_pause();
         end
      end
      // stale or unknown id now and then
      if ($urandom_range(0, 9) == 0) begin
         issue(OP_REPLY, wall_ms, ($urandom_range(0, 1) != 0) ? first - 1'b1 : $urandom,
               $urandom);
         sender_pause();
      end
   endtask

   // A few byte counts, often closed by a rate period
   task automatic bytes_round();
      int                 n;
      int                 r;
      logic [BYTES_W-1:0] bytes;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         bytes = (r == 0) ? '0 : (r == 1) ? BYTES_MAX : (r < 5) ? $urandom_range(0, 5000)
                                                                : $urandom;
         issue(OP_BYTES, $urandom, $urandom, bytes);
         sender_pause();
      end
      if ($urandom_range(0, 99) < 60) begin
         issue(OP_RATE, $urandom, $urandom, $urandom);
         sender_pause();
      end
   endtask

   // Mix of rounds until the phase has its items
   task automatic random_phase(int n_items);
      int target;
      int r;
      target = items_sent + n_items;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            ping_round();
         end else if (r < 70) begin
            bytes_round();
         end else if (r < 80) begin
            issue(OP_RATE, $urandom, $urandom, $urandom);
            sender_pause();
         end else if (r < 97) begin
            issue(op_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            sender_pause();
         end else begin
            drain();
         end
      end
   endtask

   // Directed items: edges of the fields and the special cases
   task automatic directed_items();
      logic [ID_W-1:0] base;
      issue(OP_RATE, '0, '0, '0);
      issue(OP_REPLY, '0, 32'd1, '0);
      base = pings_sent;
      issue(OP_SEND, '0, '0, '0);
      issue(OP_SEND, '1, '0, '0);
      issue(OP_SEND, 32'd12345, '0, '0);
      // reply to the second ping walks past the first; time wraps
      issue(OP_REPLY, 32'd5, base + 2, '0);
      issue(OP_REPLY, 32'd12345, base + 3, '0);
      issue(OP_REPLY, '0, '1, '0);
      issue(OP_SEND, 32'd100, '0, '0);
      // unknown id empties a live queue
      issue(OP_REPLY, 32'd200, '1, '0);
      issue(OP_BYTES, '0, '0, BYTES_MAX);
      issue(OP_BYTES, '1, '1, '0);
      issue(OP_BYTES, '0, '0, 32'hAAAA_5555);
      issue(OP_RATE, '0, '0, '0);
      issue(OP_RATE, '1, '1, '1);
      base = pings_sent;
      issue(OP_SEND, '1, '1, '1);
      issue(OP_REPLY, 32'h7FFF_FFFF, base + 1, '1);
      issue(OP_BYTES, '1, '1, 32'h5555_AAAA);
      issue(OP_RATE, '1, '1, '1);
   endtask

   // Overflow the ping queue, starting under a long receiver stall
   task automatic fill_under_hold();
      calm = 1'b1;
      long_hold_req = 1'b1;
      for (int i = 0; i < QUEUE_DEPTH + 3; i++) begin
         advance_wall();
         issue(OP_SEND, wall_ms, $urandom, $urandom);
      end
      issue(OP_REPLY, wall_ms + 7, pings_sent, '0);
      calm = 1'b0;
   endtask

   // Main stimulus
   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_mode       = OP_SEND;
      req_now_ms     = '0;
      req_reply_id   = '0;
      req_byte_count = '0;
      offering       = 1'b0;
      calm           = 1'b0;
      long_hold_req  = 1'b0;
      pings_sent     = '0;
      items_sent     = 0;
      cycle_count    = 0;
      wall_ms        = $urandom;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_items();

      // reset interval, queue overflow that starts under a long receiver stall
      fill_under_hold();
      random_phase(PHASE_ITEMS);

      // smallest interval: push the rate into saturation
      write_interval(16'd1);
      calm = 1'b1;
      for (int i = 0; i < 70; i++)
         issue(OP_BYTES, $urandom, $urandom, BYTES_MAX);
      issue(OP_RATE, '0, '0, '0);
      calm = 1'b0;
      random_phase(PHASE_ITEMS);

      write_interval(16'hFFFF);
      random_phase(PHASE_ITEMS);

      write_interval(16'd0);
      random_phase(PHASE_ITEMS);

      // no idling on either side
      write_interval(INTERVAL_W'($urandom_range(2, 65534)));
      calm = 1'b1;
      random_phase(PHASE_ITEMS);
      calm = 1'b0;

      write_interval(16'd1000);
      random_phase(PHASE_ITEMS);

      drain();
      if (fail_count == 0 && results_owed == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
